FILE: src/sha1bs_pkg.sv
// Package for the SHA-1 byte stream hasher: block and queue entry types,
// state encodings, initial chaining values and round constants. No dependencies.
package sha1bs_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int LEN_POS     = 56;
  localparam int DIGEST_MAX  = 20;
  localparam int ROUNDS      = 80;

  localparam logic [7:0]  PAD_MARK = 8'h80;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [0:0] OP_APPEND = 1'b0;
  localparam logic [0:0] OP_FINISH = 1'b1;

  typedef logic [0:BLOCK_BYTES-1][7:0] blk_bytes_t;
  typedef logic [0:15][31:0]           blk_words_t;

  typedef struct packed {
    blk_bytes_t blk;
    logic       fin;
  } blk_entry_t;

  typedef enum logic {
    FR_FILL,
    FR_PAD2
  } fr_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_FOLD,
    BK_EMIT
  } bk_state_t;

endpackage

FILE: src/sha1_byte_stream_hasher.sv
// Channel   | Signals                          | Accepted when
// input     | push, full, operation, data_byte | push && !full
// result    | empty, pop, digest_byte, last_byte | pop && !empty
// config    | cfg_write, cfg_data              | cfg_write
//
// In the front end an append adds a byte; a finish yields one or two padded blocks.
// Each full block passes the compression core as load, 80 rounds and fold;
// a two-block queue lets the front keep filling while the core runs.
// After a finish the digest leaves at one byte per cycle while pop is high.
// Reset is synchronous; the block buffer is not cleared and needs no sweep.
// Top level of the SHA-1 byte stream hasher; depends on sha1bs_pkg,
// sha1bs_front, sha1bs_blkq and sha1bs_core.
module sha1_byte_stream_hasher (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       operation,
  input  logic [7:0] data_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] digest_byte,
  output logic       last_byte,
  input  logic       cfg_write,
  input  logic [4:0] cfg_data
);
  import sha1bs_pkg::*;

  logic       fq_push;
  blk_entry_t fq_entry;
  logic       fq_full;
  logic       bq_pop;
  blk_entry_t bq_entry;
  logic       bq_valid;

  sha1bs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .data_byte (data_byte),
    .q_push    (fq_push),
    .q_entry   (fq_entry),
    .q_full    (fq_full)
  );

  sha1bs_blkq u_blkq (
    .clk      (clk),
    .rst      (rst),
    .wr       (fq_push),
    .wr_entry (fq_entry),
    .q_full   (fq_full),
    .rd       (bq_pop),
    .rd_entry (bq_entry),
    .q_valid  (bq_valid)
  );

  sha1bs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .q_valid     (bq_valid),
    .q_entry     (bq_entry),
    .q_pop       (bq_pop),
    .empty       (empty),
    .pop         (pop),
    .digest_byte (digest_byte),
    .last_byte   (last_byte)
  );

endmodule

FILE: src/sha1bs_front.sv
// Front end: takes append and finish items, fills the 64-byte block and
// builds padded blocks for the block queue. Depends on sha1bs_pkg.
module sha1bs_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   operation,
  input  logic [7:0]             data_byte,
  output logic                   q_push,
  output sha1bs_pkg::blk_entry_t q_entry,
  input  logic                   q_full
);
  import sha1bs_pkg::*;

  fr_state_t   state;
  fr_state_t   state_next;
  logic [60:0] count;
  logic [63:0] len_hold;
  blk_bytes_t  blk_buf;
  logic [5:0]  pos;
  logic [63:0] len_bits;
  logic        take;
  logic [7:0]  new_byte;

  assign pos      = count[5:0];
  assign len_bits = {count, 3'b000};

  always_comb begin
    state_next = state;
    unique case (state)
      FR_FILL: if (take && operation == OP_FINISH && pos >= 6'(LEN_POS)) state_next = FR_PAD2;
      FR_PAD2: if (!q_full) state_next = FR_FILL;
      default: state_next = FR_FILL;
    endcase
  end

  always_comb begin
    full   = (state == FR_PAD2) || q_full;
    take   = push && !full;
    q_push = 1'b0;
    unique case (state)
      FR_FILL: q_push = take && (operation == OP_FINISH || pos == 6'(BLOCK_BYTES - 1));
      FR_PAD2: q_push = !q_full;
      default: q_push = 1'b0;
    endcase
  end

  always_comb begin
    q_entry.fin = (state == FR_PAD2) ||
                  (operation == OP_FINISH && pos < 6'(LEN_POS));
    new_byte = (operation == OP_FINISH) ? PAD_MARK : data_byte;
    for (int p = 0; p < BLOCK_BYTES; p++) begin
      if (6'(p) < pos) begin
        q_entry.blk[p] = blk_buf[p];
      end else if (6'(p) == pos) begin
        q_entry.blk[p] = new_byte;
      end else begin
        q_entry.blk[p] = 8'h00;
      end
    end
    if (state == FR_PAD2) begin
      q_entry.blk = '0;
      for (int j = 0; j < 8; j++) begin
        q_entry.blk[LEN_POS + j] = len_hold[63 - 8*j -: 8];
      end
    end else if (operation == OP_FINISH && pos < 6'(LEN_POS)) begin
      for (int j = 0; j < 8; j++) begin
        q_entry.blk[LEN_POS + j] = len_bits[63 - 8*j -: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_FILL;
      count <= '0;
    end else begin
      state <= state_next;
      if (take) begin
        if (operation == OP_FINISH) begin
          count <= '0;
        end else begin
          count <= count + 61'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && operation == OP_APPEND) begin
      blk_buf[pos] <= data_byte;
    end
    if (take && operation == OP_FINISH) begin
      len_hold <= len_bits;
    end
  end

endmodule

FILE: src/sha1bs_blkq.sv
// Two-entry queue of complete blocks between the front end and the
// compression core. Depends on sha1bs_pkg.
module sha1bs_blkq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  sha1bs_pkg::blk_entry_t wr_entry,
  output logic                   q_full,
  input  logic                   rd,
  output sha1bs_pkg::blk_entry_t rd_entry,
  output logic                   q_valid
);
  import sha1bs_pkg::*;

  blk_entry_t ents [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign q_full   = (fill == 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign rd_entry = ents[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (wr && !q_full) wr_ptr <= ~wr_ptr;
      if (rd && q_valid) rd_ptr <= ~rd_ptr;
      case ({wr && !q_full, rd && q_valid})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !q_full) ents[wr_ptr] <= wr_entry;
  end

endmodule

FILE: src/sha1bs_core.sv
// Back end: 80-round SHA-1 compression, one round per cycle, chaining words
// and digest byte output. Depends on sha1bs_pkg.
module sha1bs_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [4:0]             cfg_data,
  input  logic                   q_valid,
  input  sha1bs_pkg::blk_entry_t q_entry,
  output logic                   q_pop,
  output logic                   empty,
  input  logic                   pop,
  output logic [7:0]             digest_byte,
  output logic                   last_byte
);
  import sha1bs_pkg::*;

  bk_state_t   state;
  bk_state_t   state_next;
  logic [4:0]  digest_bytes;
  logic [4:0]  n_bytes;
  logic [31:0] chain [5];
  logic [31:0] a, b, c, d, e;
  blk_words_t  w_win;
  logic [6:0]  round;
  logic        fin;
  logic [4:0]  idx;
  logic [31:0] f, k, a_new, w_new, sel_word;
  logic        emit_done;

  always_comb begin
    if (digest_bytes == 5'd0) begin
      n_bytes = 5'd1;
    end else if (digest_bytes > 5'(DIGEST_MAX)) begin
      n_bytes = 5'(DIGEST_MAX);
    end else begin
      n_bytes = digest_bytes;
    end
  end

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    a_new = {a[26:0], a[31:27]} + f + e + w_win[0] + k;
    w_new = w_win[13] ^ w_win[8] ^ w_win[2] ^ w_win[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  always_comb begin
    unique case (idx[4:2])
      3'd0:    sel_word = chain[0];
      3'd1:    sel_word = chain[1];
      3'd2:    sel_word = chain[2];
      3'd3:    sel_word = chain[3];
      default: sel_word = chain[4];
    endcase
    unique case (idx[1:0])
      2'd0:    digest_byte = sel_word[31:24];
      2'd1:    digest_byte = sel_word[23:16];
      2'd2:    digest_byte = sel_word[15:8];
      default: digest_byte = sel_word[7:0];
    endcase
  end

  assign last_byte = (idx == n_bytes - 5'd1);
  assign emit_done = (state == BK_EMIT) && pop && last_byte;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (q_valid) state_next = BK_ROUND;
      BK_ROUND: if (round == 7'(ROUNDS - 1)) state_next = BK_FOLD;
      BK_FOLD:  state_next = fin ? BK_EMIT : BK_IDLE;
      BK_EMIT:  if (emit_done) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    empty = 1'b1;
    unique case (state)
      BK_IDLE: q_pop = q_valid;
      BK_EMIT: empty = 1'b0;
      default: begin
        q_pop = 1'b0;
        empty = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      digest_bytes <= 5'(DIGEST_MAX);
      idx          <= '0;
      chain[0]     <= IV0;
      chain[1]     <= IV1;
      chain[2]     <= IV2;
      chain[3]     <= IV3;
      chain[4]     <= IV4;
    end else begin
      state <= state_next;
      if (cfg_write) digest_bytes <= cfg_data;
      if (state == BK_FOLD) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
      if (state == BK_EMIT && pop) begin
        idx <= emit_done ? 5'd0 : idx + 5'd1;
      end
      if (emit_done) begin
        chain[0] <= IV0;
        chain[1] <= IV1;
        chain[2] <= IV2;
        chain[3] <= IV3;
        chain[4] <= IV4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && q_valid) begin
      w_win <= blk_words_t'(q_entry.blk);
      fin   <= q_entry.fin;
      round <= '0;
      a     <= chain[0];
      b     <= chain[1];
      c     <= chain[2];
      d     <= chain[3];
      e     <= chain[4];
    end else if (state == BK_ROUND) begin
      w_win <= {w_win[1:15], w_new};
      round <= round + 7'd1;
      a     <= a_new;
      b     <= a;
      c     <= {b[1:0], b[31:2]};
      d     <= c;
      e     <= d;
    end
  end

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == BK_ROUND |-> round < 7'(ROUNDS))
    else $error("round counter out of range");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> idx < n_bytes)
    else $error("digest index past requested length");
  a_fin_emit: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FOLD && fin) |=> state == BK_EMIT)
    else $error("final block did not start digest output");
  a_last_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last_byte) |=> (empty && idx == 5'd0))
    else $error("output not drained after last digest byte");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == BK_IDLE)
    else $error("block taken while compression busy");
`endif

endmodule
